### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define VSEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");
// Condition must never be seen out of reset.
`define VSEC_ASSERT_NEVER(label, clk, rst_n, bad) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define VSEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define VSEC_ASSERT_NEVER(label, clk, rst_n, bad)
`endif
`endif

### sv/vsec_pkg.sv
// ----------------------------------------------------------------------------
// vsec_pkg
// Types, constants and helpers for the velocity to steer/ESC command block.
// ----------------------------------------------------------------------------
`default_nettype none

package vsec_pkg;

    localparam int unsigned BRAKE_ITEMS_DEF = 2;
    localparam int unsigned ARM_ITEMS_DEF   = 5;
    localparam int unsigned QUEUE_DEPTH     = 2;

    // Degrees per radian in Q16.
    localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754937;
    localparam logic [9:0]  MM_PER_M        = 10'd1000;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    // Divider: dividend, divisor and bounded quotient widths.
    localparam int unsigned NUM_W  = 50;
    localparam int unsigned DEN_W  = 25;
    localparam int unsigned QUO_W  = 16;
    localparam int unsigned PROD_W = NUM_W + 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WHEELBASE,
        CFG_STEER_WEIGHT,
        CFG_MAX_STEER,
        CFG_SPEED_STEP,
        CFG_THR_OFFSET,
        CFG_MAX_THR,
        CFG_MIN_THR,
        CFG_BRAKE_PULSE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_FWD,
        PH_BRAKE,
        PH_NEUTRAL,
        PH_REV
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_S,
        ST_WAIT_S,
        ST_DIV_T,
        ST_WAIT_T,
        ST_DONE
    } t_bstate;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
    } t_in;

    typedef struct packed {
        logic signed [16:0] throttle_cmd;
        logic signed [15:0] steer_cmd;
        logic [1:0]         reverse_phase;
    } t_out;

    typedef struct packed {
        logic [11:0] wheelbase_mm;
        logic [7:0]  steer_weight;
        logic [6:0]  max_steer_deg;
        logic [11:0] speed_per_step;
        logic [7:0]  throttle_offset;
        logic [7:0]  max_throttle;
        logic [7:0]  min_throttle;
        logic [7:0]  brake_pulse;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        wheelbase_mm:    12'd85,
        steer_weight:    8'd80,
        max_steer_deg:   7'd20,
        speed_per_step:  12'd178,
        throttle_offset: 8'd5,
        max_throttle:    8'd30,
        min_throttle:    8'd6,
        brake_pulse:     8'd8
    };

    // Classified item handed from front to back.
    typedef struct packed {
        logic [15:0] aspd;
        logic [15:0] atrn;
        logic        spd_neg;
        logic        trn_neg;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

    // Clamp a Q8 magnitude to top whole units, then zero it when its whole
    // part is at or below floor_w. sat marks a value beyond 17 bits.
    function automatic logic [16:0] f_clamp_q8(
        input logic        sat,
        input logic [16:0] val,
        input logic [7:0]  top,
        input logic [7:0]  floor_w
    );
        logic [16:0] v;
        v = val;
        if (sat || (val[16:8] > {1'b0, top})) begin
            v = {1'b0, top, 8'h00};
        end
        if (v[16:8] <= {1'b0, floor_w}) begin
            v = '0;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/vsec_div.sv
// ----------------------------------------------------------------------------
// vsec_div
// Restoring divider with a saturating 16-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vsec_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vsec_pkg::t_div_req i_req,
    output vsec_pkg::t_div_rsp      o_rsp
);

    localparam int unsigned SH_W  = vsec_pkg::DEN_W + vsec_pkg::QUO_W;
    localparam int unsigned CNT_W = $clog2(vsec_pkg::QUO_W);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_sat;
    logic [vsec_pkg::QUO_W-1:0] r_q;
    logic [SH_W-1:0]            r_rem;
    logic [SH_W-1:0]            r_dsh;
    logic [CNT_W-1:0]           r_cnt;

    logic [SH_W-1:0] w_full_den;
    logic            w_sat;
    logic            w_ge;
    logic [SH_W-1:0] w_diff;

    // Quotient would not fit in QUO_W bits.
    assign w_full_den = {i_req.divisor, {vsec_pkg::QUO_W{1'b0}}};
    assign w_sat      = i_req.dividend >= {{(vsec_pkg::NUM_W - SH_W){1'b0}}, w_full_den};
    assign w_ge       = r_rem >= r_dsh;
    assign w_diff     = r_rem - r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sat <= w_sat;
            r_q   <= '0;
            r_rem <= i_req.dividend[SH_W-1:0];
            r_dsh <= {1'b0, i_req.divisor, {(vsec_pkg::QUO_W - 1){1'b0}}};
            r_cnt <= CNT_W'(vsec_pkg::QUO_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff;
            end
            r_q   <= {r_q[vsec_pkg::QUO_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

### sv/vsec_back.sv
// ----------------------------------------------------------------------------
// vsec_back
// Sequencer: steering geometry, throttle scaling, ESC reverse arming.
// ----------------------------------------------------------------------------
`default_nettype none

module vsec_back #(
    parameter int unsigned BRAKE_ITEMS = vsec_pkg::BRAKE_ITEMS_DEF,
    parameter int unsigned ARM_ITEMS   = vsec_pkg::ARM_ITEMS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vsec_pkg::t_cfg i_cfg,
    input  wire vsec_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output vsec_pkg::t_out      o_out
);

    localparam int unsigned PROD_W = vsec_pkg::PROD_W;

    vsec_pkg::t_bstate  r_state;
    vsec_pkg::t_bstate  n_state;
    vsec_pkg::t_job     r_job;
    logic [PROD_W-1:0]  r_prod;
    logic [vsec_pkg::DEN_W-1:0] r_den;
    logic [15:0]        r_steer;
    logic [16:0]        r_thr;
    logic [2:0]         r_rev_cnt;
    logic [2:0]         n_rev_cnt;
    vsec_pkg::t_out     r_out;
    logic               r_out_valid;

    vsec_pkg::t_div_req w_div_req;
    vsec_pkg::t_div_rsp w_div_rsp;
    vsec_pkg::t_out     w_out;
    vsec_pkg::t_phase   w_phase;

    logic        w_skip;
    logic        w_out_free;
    logic [19:0] w_mul_a;
    logic [25:0] w_den_full;
    logic [41:0] w_mul_b;
    logic [PROD_W-1:0] w_mul_c;
    logic [11:0] w_step;
    logic [16:0] w_steer_sat;
    logic [16:0] w_steer_div;
    logic [16:0] w_thr_sum;
    logic [16:0] w_thr_mag;
    logic [16:0] w_brake;

    vsec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // No geometry work when either input is zero.
    assign w_skip      = (i_job.atrn == '0) || (i_job.aspd == '0);
    assign w_out_free  = !r_out_valid || i_pop;

    assign w_mul_a     = i_cfg.wheelbase_mm * i_cfg.steer_weight;
    assign w_den_full  = r_job.aspd * vsec_pkg::MM_PER_M;
    assign w_mul_b     = r_prod[19:0] * vsec_pkg::DEG_PER_RAD_Q16;
    assign w_mul_c     = r_prod[41:0] * r_job.atrn;
    assign w_step      = (i_cfg.speed_per_step == '0) ? 12'd1 : i_cfg.speed_per_step;

    assign w_steer_sat = vsec_pkg::f_clamp_q8(1'b1, '0, {1'b0, i_cfg.max_steer_deg}, 8'd0);
    assign w_steer_div = vsec_pkg::f_clamp_q8(w_div_rsp.sat, {1'b0, w_div_rsp.quot},
                                              {1'b0, i_cfg.max_steer_deg}, 8'd0);
    assign w_thr_sum   = {1'b0, w_div_rsp.quot} + {1'b0, i_cfg.throttle_offset, 8'h00};
    assign w_thr_mag   = vsec_pkg::f_clamp_q8(w_div_rsp.sat, w_thr_sum,
                                              i_cfg.max_throttle, i_cfg.min_throttle);
    assign w_brake     = {1'b0, i_cfg.brake_pulse, 8'h00};

    // Next state and handshakes.
    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        w_div_req = '0;
        case (r_state)
            vsec_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = w_skip ? vsec_pkg::ST_DIV_T : vsec_pkg::ST_MUL_A;
                end
            end
            vsec_pkg::ST_MUL_A: n_state = vsec_pkg::ST_MUL_B;
            vsec_pkg::ST_MUL_B: n_state = vsec_pkg::ST_MUL_C;
            vsec_pkg::ST_MUL_C: n_state = vsec_pkg::ST_DIV_S;
            vsec_pkg::ST_DIV_S: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = r_prod[PROD_W-1:8];
                w_div_req.divisor  = r_den;
                n_state            = vsec_pkg::ST_WAIT_S;
            end
            vsec_pkg::ST_WAIT_S: begin
                if (w_div_rsp.done) begin
                    n_state = vsec_pkg::ST_DIV_T;
                end
            end
            vsec_pkg::ST_DIV_T: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = vsec_pkg::NUM_W'({r_job.aspd, 8'h00});
                w_div_req.divisor  = vsec_pkg::DEN_W'(w_step);
                n_state            = vsec_pkg::ST_WAIT_T;
            end
            vsec_pkg::ST_WAIT_T: begin
                if (w_div_rsp.done) begin
                    n_state = vsec_pkg::ST_DONE;
                end
            end
            vsec_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = vsec_pkg::ST_IDLE;
                end
            end
            default: n_state = vsec_pkg::ST_IDLE;
        endcase
    end

    // Reverse arming and result word.
    always_comb begin
        n_rev_cnt = r_rev_cnt;
        w_phase   = vsec_pkg::PH_FWD;
        w_out.throttle_cmd = r_thr;
        if (r_job.spd_neg) begin
            if (r_rev_cnt < 3'(BRAKE_ITEMS)) begin
                n_rev_cnt          = r_rev_cnt + 3'd1;
                w_phase            = vsec_pkg::PH_BRAKE;
                w_out.throttle_cmd = 17'd0 - w_brake;
            end else if (r_rev_cnt < 3'(ARM_ITEMS)) begin
                n_rev_cnt          = r_rev_cnt + 3'd1;
                w_phase            = vsec_pkg::PH_NEUTRAL;
                w_out.throttle_cmd = '0;
            end else begin
                w_phase            = vsec_pkg::PH_REV;
                w_out.throttle_cmd = 17'd0 - r_thr;
            end
        end else begin
            n_rev_cnt = '0;
        end
        w_out.steer_cmd     = r_job.trn_neg ? (16'd0 - r_steer) : r_steer;
        w_out.reverse_phase = w_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vsec_pkg::ST_IDLE;
            r_rev_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == vsec_pkg::ST_DONE) && w_out_free) begin
                r_rev_cnt   <= n_rev_cnt;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            vsec_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    r_job   <= i_job;
                    r_steer <= (i_job.atrn == '0) ? 16'd0 : w_steer_sat[15:0];
                end
            end
            vsec_pkg::ST_MUL_A: begin
                r_prod <= PROD_W'(w_mul_a);
                r_den  <= w_den_full[vsec_pkg::DEN_W-1:0];
            end
            vsec_pkg::ST_MUL_B: r_prod <= PROD_W'(w_mul_b);
            vsec_pkg::ST_MUL_C: r_prod <= w_mul_c;
            vsec_pkg::ST_WAIT_S: begin
                if (w_div_rsp.done) begin
                    r_steer <= w_steer_div[15:0];
                end
            end
            vsec_pkg::ST_WAIT_T: begin
                if (w_div_rsp.done) begin
                    r_thr <= w_thr_mag;
                end
            end
            vsec_pkg::ST_DONE: begin
                if (w_out_free) begin
                    r_out <= w_out;
                end
            end
            default: ;
        endcase
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

### sv/vsec_front.sv
// ----------------------------------------------------------------------------
// vsec_front
// Input side: take words, split sign and magnitude, queue them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module vsec_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire vsec_pkg::t_in i_in,
    input  wire logic          i_pop,
    output vsec_pkg::t_job     o_job,
    output logic               o_job_valid
);

    localparam int unsigned DEPTH = vsec_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    vsec_pkg::t_job   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    vsec_pkg::t_job w_job;
    logic           w_wr;
    logic           w_rd;

    always_comb begin
        w_job.spd_neg = i_in.linear_speed[15];
        w_job.trn_neg = i_in.turn_rate[15];
        w_job.aspd    = w_job.spd_neg ? (16'd0 - $unsigned(i_in.linear_speed))
                                      : $unsigned(i_in.linear_speed);
        w_job.atrn    = w_job.trn_neg ? (16'd0 - $unsigned(i_in.turn_rate))
                                      : $unsigned(i_in.turn_rate);
    end

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_slot[r_rd_ptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= w_job;
        end
    end

endmodule

`default_nettype wire

### sv/velocity_to_steer_and_esc_command.sv
// ----------------------------------------------------------------------------
// velocity_to_steer_and_esc_command
// Turns a speed / yaw-rate word into throttle, steering and ESC reverse phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: write a word (linear_speed mm/s, turn_rate mrad/s) with
//   push while full is low. Up to two words wait in the input queue.
//   Result channel: while empty is low the oldest result (throttle_cmd,
//   steer_cmd, reverse_phase) sits on o_out; pop takes it.
//   Config channel: i_cfg_valid with index and data; o_cfg_ready is always
//   high. Write registers only while the block is idle.
//   Sequence: the shared 16-step divider makes one pass for the steering
//   angle and one for the throttle, with the multiply steps MUL_A, MUL_B
//   and MUL_C ahead of the first pass. When speed or turn rate is zero the
//   multiplies and the steering pass are skipped. A pass whose quotient
//   would overflow 16 bits ends without stepping, saturated.
//   Reset: config registers return to their defaults, both queues empty,
//   reverse arming count cleared.
//   Stall: a result not popped holds the sequencer in its last step; the
//   input queue keeps taking words until it fills, then full goes high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module velocity_to_steer_and_esc_command #(
    parameter int unsigned BRAKE_ITEMS = vsec_pkg::BRAKE_ITEMS_DEF,
    parameter int unsigned ARM_ITEMS   = vsec_pkg::ARM_ITEMS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input word queue
    input  wire logic                                push,
    output logic                                     full,
    input  wire vsec_pkg::t_in                       i_in,
    // result word queue
    output logic                                     empty,
    input  wire logic                                pop,
    output vsec_pkg::t_out                           o_out,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [vsec_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [vsec_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    vsec_pkg::t_cfg r_cfg;
    vsec_pkg::t_job w_job;
    logic           w_job_valid;
    logic           w_job_pop;
    logic signed [16:0] w_steer_lim;
    logic           w_fwd_neg;
    logic           w_neutral;
    logic           w_steer_ok;

    // Config registers: always ready, truncate data to the register width.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= vsec_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (vsec_pkg::t_cfg_idx'(i_cfg_index))
                vsec_pkg::CFG_WHEELBASE:    r_cfg.wheelbase_mm    <= i_cfg_data;
                vsec_pkg::CFG_STEER_WEIGHT: r_cfg.steer_weight    <= i_cfg_data[7:0];
                vsec_pkg::CFG_MAX_STEER:    r_cfg.max_steer_deg   <= i_cfg_data[6:0];
                vsec_pkg::CFG_SPEED_STEP:   r_cfg.speed_per_step  <= i_cfg_data;
                vsec_pkg::CFG_THR_OFFSET:   r_cfg.throttle_offset <= i_cfg_data[7:0];
                vsec_pkg::CFG_MAX_THR:      r_cfg.max_throttle    <= i_cfg_data[7:0];
                vsec_pkg::CFG_MIN_THR:      r_cfg.min_throttle    <= i_cfg_data[7:0];
                vsec_pkg::CFG_BRAKE_PULSE:  r_cfg.brake_pulse     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: classify and queue input words.
    vsec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .i_pop       (w_job_pop),
        .o_job       (w_job),
        .o_job_valid (w_job_valid)
    );

    // Back: multiply, divide, clamp, run the reverse arming sequence.
    vsec_back #(
        .BRAKE_ITEMS (BRAKE_ITEMS),
        .ARM_ITEMS   (ARM_ITEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

    // Steering magnitude limit in Q8 degrees.
    assign w_steer_lim = $signed({2'b00, r_cfg.max_steer_deg, 8'h00});

    // Conditions watched on the waiting result word.
    assign w_fwd_neg  = !empty && (o_out.reverse_phase == vsec_pkg::PH_FWD)
                        && o_out.throttle_cmd[16];
    assign w_neutral  = !empty && (o_out.reverse_phase == vsec_pkg::PH_NEUTRAL);
    assign w_steer_ok = ($signed(o_out.steer_cmd) <= w_steer_lim)
                        && ($signed(o_out.steer_cmd) >= -w_steer_lim);

    `VSEC_ASSERT_NEVER(a_fwd_nonneg, i_clk, i_rst_n, w_fwd_neg)
    `VSEC_ASSERT_IMPLY(a_neutral_zero, i_clk, i_rst_n, w_neutral, o_out.throttle_cmd == '0)
    `VSEC_ASSERT_IMPLY(a_steer_bound, i_clk, i_rst_n, !empty, w_steer_ok)

endmodule

`default_nettype wire
